FILE: hdl/drrb_pkg.sv
// Shared constants, codes and types of the dual-port receive ring buffer.
package drrb_pkg;

   localparam int BUFFER_BYTES = 16384;
   localparam int MAX_CHANNELS = 2;

   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   // pointers may reach the region length itself, so one more value is needed
   localparam int PTR_W  = $clog2(BUFFER_BYTES + 1);
   localparam int KIND_W = 2;
   localparam int PORTS_W = 2;

   localparam int REGION_ONE = BUFFER_BYTES;
   localparam int REGION_TWO = BUFFER_BYTES / 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_RECV = 2'd0,
      KIND_READ = 2'd1,
      KIND_OPEN = 2'd2
   } kind_type;

   typedef logic [PTR_W-1:0] ptr_type;

   // a register value above one selects the split layout when two channels fit
   function automatic logic two_ports(input logic [PORTS_W-1:0] installed);
      return (MAX_CHANNELS >= 2) && (installed >= PORTS_W'(2));
   endfunction

endpackage

FILE: hdl/dual_port_receive_ring_buffer_core.sv
// Top level of the dual-port receive ring buffer: pointers, control and byte memory.
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------------
//  request   | req_kind, req_channel, req_rx_byte             | start high, busy low
//  response  | rsp_out_channel, rsp_has_data, rsp_read_byte   | rsp_strobe, one cycle
//  control   | csr_wdata (installed_ports)                    | csr_valid and csr_ready
//
//  One word is taken every cycle; busy stays low. A read returns its word in the
//  cycle after acceptance, from the registered read port of the byte memory.
//  Pointers live in flops and update at acceptance, so back-to-back words see
//  each other's pointer moves; a write followed by a read of that entry lands
//  in the memory first. Reset clears pointers and sets one installed channel;
//  the byte memory keeps its contents. The receiver cannot stall responses.
module dual_port_receive_ring_buffer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [drrb_pkg::KIND_W-1:0]   req_kind,
   input  logic                          req_channel,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_strobe,
   output logic                          rsp_out_channel,
   output logic                          rsp_has_data,
   output logic [7:0]                    rsp_read_byte,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [drrb_pkg::PORTS_W-1:0]  csr_wdata
);
   import drrb_pkg::*;

   logic [PORTS_W-1:0] ports_ff, ports_in;
   ptr_type            wp_ff [2];
   ptr_type            rp_ff [2];
   ptr_type            wp_in, rp_in;

   logic               strobe_ff, strobe_in;
   logic               chan_ff, chan_in;
   logic               has_ff, has_in;

   logic               accept, split, present;
   kind_type           kind;
   ptr_type            region_len, base;
   ptr_type            wp_cur, wp_fix, wp_inc, rp_cur, rp_fix;
   logic               empty;
   logic               wr_en, rd_en, wp_we, rp_we;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [7:0]         rd_data;

   // accept every cycle; the user must send configuration only while idle, the block does not enforce this
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign kind      = kind_type'(req_kind);

   // region geometry from the installed channel count
   assign split      = two_ports(ports_ff);
   assign region_len = split ? PTR_W'(REGION_TWO) : PTR_W'(REGION_ONE);
   assign present    = !req_channel || split;
   assign base       = req_channel ? PTR_W'(REGION_TWO) : '0;

   // write side: fold an out-of-region pointer, store, advance with wrap
   assign wp_cur = wp_ff[req_channel];
   assign wp_fix = (wp_cur >= region_len) ? '0 : wp_cur;
   assign wp_inc = wp_fix + PTR_W'(1);

   // read side: fold first, then compare against the raw write pointer
   assign rp_cur = rp_ff[req_channel];
   assign rp_fix = (rp_cur >= region_len) ? '0 : rp_cur;
   assign empty  = (rp_fix == wp_cur);

   assign wr_addr = ADDR_W'(base + wp_fix);
   assign rd_addr = ADDR_W'(base + rp_fix);

   always_comb begin
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wp_we     = 1'b0;
      rp_we     = 1'b0;
      wp_in     = wp_cur;
      rp_in     = rp_cur;
      strobe_in = 1'b0;
      chan_in   = chan_ff;
      has_in    = has_ff;
      if (accept) begin
         unique case (kind)
            KIND_RECV: begin
               if (present) begin
                  wr_en = 1'b1;
                  wp_we = 1'b1;
                  wp_in = (wp_inc == region_len) ? '0 : wp_inc;
               end
            end
            KIND_READ: begin
               strobe_in = 1'b1;
               chan_in   = req_channel;
               has_in    = present && !empty;
               if (present) begin
                  rp_we = 1'b1;
                  rd_en = !empty;
                  rp_in = empty ? rp_fix : rp_fix + PTR_W'(1);
               end
            end
            KIND_OPEN: begin
               if (present) begin
                  wp_we = 1'b1;
                  rp_we = 1'b1;
                  wp_in = '0;
                  rp_in = '0;
               end
            end
            default: begin
               // unused code: drop the word
            end
         endcase
      end
   end

   always_comb begin
      ports_in = ports_ff;
      if (csr_valid && csr_ready) begin
         ports_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff  <= PORTS_W'(1);
         wp_ff[0]  <= '0;
         wp_ff[1]  <= '0;
         rp_ff[0]  <= '0;
         rp_ff[1]  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ports_ff  <= ports_in;
         strobe_ff <= strobe_in;
         if (wp_we) begin
            wp_ff[req_channel] <= wp_in;
         end
         if (rp_we) begin
            rp_ff[req_channel] <= rp_in;
         end
      end
   end

   // response payload holds alongside the memory's read register
   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      has_ff  <= has_in;
   end

   drrb_byte_ram #(
      .DEPTH  (BUFFER_BYTES),
      .WIDTH  (8),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // zero the byte when nothing was returned
   assign rsp_strobe      = strobe_ff;
   assign rsp_out_channel = chan_ff;
   assign rsp_has_data    = has_ff;
   assign rsp_read_byte   = has_ff ? rd_data : 8'd0;

`ifndef SYNTHESIS
   a_read_gives_strobe: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind == KIND_READ)) |=> rsp_strobe)
      else $error("read word produced no response");

   a_no_stray_strobe: assert property (@(posedge clock) disable iff (reset)
      !(accept && (kind == KIND_READ)) |=> !rsp_strobe)
      else $error("response without a read word");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wp_ff[0] < PTR_W'(BUFFER_BYTES)) && (wp_ff[1] < PTR_W'(BUFFER_BYTES)) &&
      (rp_ff[0] <= PTR_W'(BUFFER_BYTES)) && (rp_ff[1] <= PTR_W'(BUFFER_BYTES)))
      else $error("pointer outside the byte memory");

   a_data_needs_read: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind == KIND_READ) && !present) |=> !rsp_has_data)
      else $error("data returned for a channel that is not installed");
`endif

endmodule

FILE: hdl/drrb_byte_ram.sv
// Simple dual-port byte memory: one write port, one registered read port.
module drrb_byte_ram #(
   parameter int DEPTH  = 16384,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/dual_port_receive_ring_buffer_core_tb.sv
// Self-checking testbench of the dual-port receive ring buffer core.
module dual_port_receive_ring_buffer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import drrb_pkg::*;

   // Raw kind code that the block has no operation for; it must be dropped.
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 210;
   localparam logic [PORTS_W-1:0] RANDOM_PORTS [6] = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1};

   // One read answer, in the order of the response ports.
   typedef struct packed {
      logic       channel;
      logic       has_data;
      logic [7:0] data;
   } rx_read_type;

   // One line of the directed table: either a register write or a request word,
   // optionally with the answer typed in by hand.
   typedef struct packed {
      bit                  is_cfg;
      logic [PORTS_W-1:0]  cfg_value;
      logic [KIND_W-1:0]   kind;
      logic                channel;
      logic [7:0]          data;
      bit                  typed;
      rx_read_type         answer;
   } stim_row_type;

   localparam int DIR_ROWS = 30;
   localparam stim_row_type DIRECTED [DIR_ROWS] = '{
      // fresh after reset: empty channel 0, channel 1 not installed
      '{1'b0, 2'd0, KIND_READ,  1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 8'h00}},
      '{1'b0, 2'd0, KIND_READ,  1'b1, 8'h00, 1'b1, '{1'b1, 1'b0, 8'h00}},
      // words for the missing channel are dropped
      '{1'b0, 2'd0, KIND_RECV,  1'b1, 8'hAA, 1'b0, '0},
      '{1'b0, 2'd0, KIND_OPEN,  1'b1, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_RECV,  1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_RECV,  1'b0, 8'hFF, 1'b0, '0},
      '{1'b0, 2'd0, KIND_RECV,  1'b0, 8'h5A, 1'b0, '0},
      '{1'b0, 2'd0, KIND_SPARE, 1'b1, 8'hA5, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b0, 8'h00, 1'b0, '0},
      // open drops the unread byte
      '{1'b0, 2'd0, KIND_OPEN,  1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 8'h00}},
      // store then read the same entry back to back
      '{1'b0, 2'd0, KIND_RECV,  1'b0, 8'h81, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 8'h00}},
      // split layout: channel 1 owns the upper half
      '{1'b1, 2'd2, KIND_RECV,  1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_RECV,  1'b1, 8'h7E, 1'b0, '0},
      '{1'b0, 2'd0, KIND_RECV,  1'b1, 8'h01, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b1, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b1, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b1, 8'h00, 1'b1, '{1'b1, 1'b0, 8'h00}},
      '{1'b0, 2'd0, KIND_READ,  1'b0, 8'h00, 1'b0, '0},
      // register above the channel count acts as two
      '{1'b1, 2'd3, KIND_RECV,  1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_RECV,  1'b1, 8'hC3, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b1, 8'h00, 1'b0, '0},
      // register of zero acts as one
      '{1'b1, 2'd0, KIND_RECV,  1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 2'd0, KIND_READ,  1'b1, 8'h00, 1'b1, '{1'b1, 1'b0, 8'h00}},
      '{1'b0, 2'd0, KIND_RECV,  1'b1, 8'h3C, 1'b0, '0},
      '{1'b0, 2'd0, KIND_OPEN,  1'b0, 8'h00, 1'b0, '0},
      '{1'b1, 2'd1, KIND_RECV,  1'b0, 8'h00, 1'b0, '0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_RECV;
   logic                req_channel = 1'b0;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_strobe;
   logic                rsp_out_channel;
   logic                rsp_has_data;
   logic [7:0]          rsp_read_byte;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PORTS_W-1:0]  csr_wdata = 2'd1;

   // Shadow of the buffer: byte memory, which entries hold a byte, pointers, register.
   logic [7:0]          shadow_mem [BUFFER_BYTES];
   bit                  written_map [BUFFER_BYTES];
   int unsigned         wr_ptr [2];
   int unsigned         rd_ptr [2];
   logic [PORTS_W-1:0]  ports_reg = 2'd1;

   // Read answers still owed by the block, oldest first.
   rx_read_type         pending_reads [$];

   // Hand-typed answer that rides along with the word on the request ports.
   bit                  typed_on = 1'b0;
   rx_read_type         typed_rsp = '0;

   int                  mismatch_count = 0;
   int                  burst_left = 0;

   dual_port_receive_ring_buffer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_channel     (req_channel),
      .req_rx_byte     (req_rx_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_channel (rsp_out_channel),
      .rsp_has_data    (rsp_has_data),
      .rsp_read_byte   (rsp_read_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp the register into 1..MAX_CHANNELS.
   function automatic int unsigned active_ports();
      int unsigned n;
      n = ports_reg;
      if (n < 1) n = 1;
      if (n > MAX_CHANNELS) n = MAX_CHANNELS;
      return n;
   endfunction

   // Apply one accepted word to the shadow; return 1 when it owes a read answer.
   function automatic bit step_buffer(input logic [KIND_W-1:0] kind, input logic ch,
                                      input logic [7:0] data, output rx_read_type answer);
      int unsigned ports;
      int unsigned len;
      int unsigned base;
      int unsigned ptr;
      bit          present;
      ports   = active_ports();
      len     = BUFFER_BYTES / ports;
      base    = int'(ch) * len;
      present = int'(ch) < ports;
      answer  = '0;
      unique case (kind)
         KIND_RECV: begin
            if (present) begin
               // a pointer left outside the region by a layout change restarts at 0
               ptr = wr_ptr[ch];
               if (ptr >= len) ptr = 0;
               shadow_mem[base + ptr]  = data;
               written_map[base + ptr] = 1'b1;
               ptr++;
               if (ptr == len) ptr = 0;
               wr_ptr[ch] = ptr;
            end
            return 1'b0;
         end
         KIND_READ: begin
            answer.channel = ch;
            if (present) begin
               ptr = rd_ptr[ch];
               if (ptr >= len) ptr = 0;
               if (ptr != wr_ptr[ch]) begin
                  answer.has_data = 1'b1;
                  answer.data     = shadow_mem[base + ptr];
                  ptr++;
               end
               rd_ptr[ch] = ptr;
            end
            return 1'b1;
         end
         KIND_OPEN: begin
            if (present) begin
               wr_ptr[ch] = 0;
               rd_ptr[ch] = 0;
            end
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // True when a read of this channel now would fetch an entry never stored.
   function automatic bit reads_unwritten(input logic ch);
      int unsigned ports;
      int unsigned len;
      int unsigned ptr;
      ports = active_ports();
      len   = BUFFER_BYTES / ports;
      if (int'(ch) >= ports) return 1'b0;
      ptr = rd_ptr[ch];
      if (ptr >= len) ptr = 0;
      if (ptr == wr_ptr[ch]) return 1'b0;
      return !written_map[int'(ch) * len + ptr];
   endfunction

   // Drop start; n sets how long it stays low.
   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Send in bursts of random length; roughly one burst in four runs straight on.
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
      end
      burst_left--;
   endtask

   // Drive one request word and hold it until the block takes it.
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic ch,
                            input logic [7:0] data, input bit typed,
                            input rx_read_type answer);
      pace();
      @(negedge clock);
      // steer away from fetching a never-written entry: reopen the channel instead
      if (kind == KIND_READ && reads_unwritten(ch)) begin
         kind  = KIND_OPEN;
         typed = 1'b0;
      end
      start       = 1'b1;
      req_kind    = kind;
      req_channel = ch;
      req_rx_byte = data;
      typed_on    = typed;
      typed_rsp   = answer;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Repeat one kind of word on one channel with random bytes.
   task automatic stream(input logic [KIND_W-1:0] kind, input logic ch, input int count);
      repeat (count) send_word(kind, ch, 8'($urandom), 1'b0, '0);
   endtask

   // Write the channel count once the block has gone quiet.
   task automatic write_ports(input logic [PORTS_W-1:0] value);
      @(negedge clock);
      start = 1'b0;
      while (pending_reads.size() != 0) @(negedge clock);
      // let any word without an answer settle before touching the layout
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Track register writes and accepted words, then check each answer against
   // the oldest one owed. Predict before checking so a same-cycle answer still works.
   always @(posedge clock) begin
      rx_read_type predicted;
      rx_read_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) ports_reg = csr_wdata;
         if (start && !busy) begin
            if (step_buffer(req_kind, req_channel, req_rx_byte, predicted))
               pending_reads.push_back(typed_on ? typed_rsp : predicted);
         end
         if (rsp_strobe) begin
            if (pending_reads.size() == 0) begin
               $error("read answer with none owed: channel %0d has_data %0d byte %0h",
                      rsp_out_channel, rsp_has_data, rsp_read_byte);
               mismatch_count++;
            end else begin
               want = pending_reads.pop_front();
               if (rsp_out_channel !== want.channel) begin
                  $error("rsp_out_channel: expected %0d, actual %0d",
                         want.channel, rsp_out_channel);
                  mismatch_count++;
               end
               if (rsp_has_data !== want.has_data) begin
                  $error("rsp_has_data: expected %0d, actual %0d",
                         want.has_data, rsp_has_data);
                  mismatch_count++;
               end
               if (rsp_read_byte !== want.data) begin
                  $error("rsp_read_byte: expected %0h, actual %0h",
                         want.data, rsp_read_byte);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      int          issued;
      int unsigned pick;
      logic [KIND_W-1:0] kind;
      logic        ch;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: extremes, every kind, the odd register values.
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIRECTED[r].is_cfg)
            write_ports(DIRECTED[r].cfg_value);
         else
            send_word(DIRECTED[r].kind, DIRECTED[r].channel, DIRECTED[r].data,
                      DIRECTED[r].typed, DIRECTED[r].answer);
      end

      // Short run of stores then reads on channel 0 in the split layout; read past the end.
      write_ports(2'd2);
      send_word(KIND_OPEN, 1'b0, 8'h00, 1'b0, '0);
      stream(KIND_RECV, 1'b0, 10);
      stream(KIND_READ, 1'b0, 12);

      // Random phases, one register setting each.
      foreach (RANDOM_PORTS[p]) begin
         write_ports(RANDOM_PORTS[p]);
         issued = 0;
         while (issued < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      kind = KIND_RECV;
            else if (pick < 88) kind = KIND_READ;
            else if (pick < 95) kind = KIND_OPEN;
            else                kind = KIND_SPARE;
            // favor installed channels; keep a trickle of words to the missing one
            if (active_ports() == 1 && $urandom_range(0, 9) != 0)
               ch = 1'b0;
            else
               ch = 1'($urandom_range(0, 1));
            send_word(kind, ch, 8'($urandom), 1'b0, '0);
            if (kind != KIND_SPARE) issued++;
         end
      end

      // Drain: stop sending, wait for every owed answer, then let the block idle before the verdict.
      @(negedge clock);
      start = 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: files.f
hdl/drrb_pkg.sv
hdl/drrb_byte_ram.sv
hdl/dual_port_receive_ring_buffer_core.sv
tb/dual_port_receive_ring_buffer_core_tb.sv
